/* src/i2a_pkg.sv */
`timescale 1ns / 1ps

package i2a_pkg;

	localparam int NCELL     = 16;
	localparam int DIGIT_W   = 4;
	localparam int VALUE_W   = 64;
	localparam int OP_W      = 3;
	localparam int CHAR_W    = 8;
	localparam int BIN_W     = 32;
	localparam int LEFT_W    = $clog2(NCELL + 1);
	localparam int CONV_W    = $clog2(BIN_W);

	localparam logic [OP_W-1:0] OP_SDEC = 3'd0;
	localparam logic [OP_W-1:0] OP_UDEC = 3'd1;
	localparam logic [OP_W-1:0] OP_HEXL = 3'd2;
	localparam logic [OP_W-1:0] OP_HEXU = 3'd3;
	localparam logic [OP_W-1:0] OP_PTR  = 3'd4;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [OP_W-1:0]    op;
	} i2a_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              last;
	} i2a_out_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic nshift;
	} i2a_cell_ctrl_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] base;
		base = upper ? CH_UA : CH_LA;
		if (d < 4'd10)
			return CH_ZERO + {4'd0, d};
		else
			return base + {4'd0, d} - 8'd10;
	endfunction

endpackage

/* src/i2a_cell.sv */
`timescale 1ns / 1ps

module i2a_cell import i2a_pkg::*; (
	input  logic                clk,
	input  i2a_cell_ctrl_t      ctrl,
	input  logic [DIGIT_W-1:0]  load_digit,
	input  logic                bit_in,
	input  logic [DIGIT_W-1:0]  digit_in,
	output logic [DIGIT_W-1:0]  digit,
	output logic                bit_out
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// add-3 correction before the shift
	assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	assign bit_out = adj[DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.load)
			digit_q <= load_digit;
		else if (ctrl.dabble)
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		else if (ctrl.nshift)
			digit_q <= digit_in;
	end

endmodule

/* src/integer_to_ascii_formatter.sv */
`timescale 1ns / 1ps

// Formats one integer as printf-style %d, %u, %x, %X or %p text, one ASCII
// character per output item, most significant first, last set on the final
// character; op codes 5 to 7 are taken and give no output. Digits live in a
// row of sixteen 4-bit cells. Decimal kinds run a binary-to-BCD conversion
// through the row, one input bit per cycle; hex kinds load the row in the
// accept cycle. Leading zeros then shift out at one cell per cycle (up to 15
// cells, so at least one digit stays), the sign or 0x prefix goes out at one
// character per cycle when the output is free, and each digit leaves the top
// cell at one per cycle when the output is free. One item is in work at a
// time; the next item is accepted once the last character is registered.
module integer_to_ascii_formatter import i2a_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  i2a_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output i2a_out_t rsp
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_SKIP = 3'd2;
	localparam logic [2:0] ST_PRE  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]            state_q;
	logic [BIN_W-1:0]      bin_q;
	logic [CONV_W-1:0]     conv_q;
	logic [LEFT_W-1:0]     left_q;
	logic [1:0]            pre_q;
	logic                  ptr_q;
	logic                  upper_q;
	logic                  rsp_valid_q;
	i2a_out_t              rsp_q;

	logic                  accept;
	logic                  op_ok;
	logic                  is_dec;
	logic                  is_neg;
	logic [BIN_W-1:0]      low;
	logic [VALUE_W-1:0]    ld_vec;
	logic                  can_push;
	logic                  push;
	i2a_out_t              push_item;
	i2a_cell_ctrl_t        cell_ctrl;
	logic [DIGIT_W-1:0]    top_digit;

	logic [DIGIT_W-1:0]    digit_w [NCELL];
	logic                  bit_w   [NCELL];

	assign low    = req.value[BIN_W-1:0];
	assign op_ok  = (req.op == OP_SDEC) || (req.op == OP_UDEC) || (req.op == OP_HEXL) ||
	                (req.op == OP_HEXU) || (req.op == OP_PTR);
	assign is_dec = (req.op == OP_SDEC) || (req.op == OP_UDEC);
	assign is_neg = (req.op == OP_SDEC) && low[BIN_W-1];

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		if (req.op == OP_PTR)
			ld_vec = req.value;
		else if (is_dec)
			ld_vec = '0;
		else
			ld_vec = {{(VALUE_W-BIN_W){1'b0}}, low};
	end

	assign can_push  = !rsp_valid_q || rsp_ready;
	assign top_digit = digit_w[NCELL-1];

	always_comb begin
		push      = 1'b0;
		push_item = '{char_out: CH_ZERO, last: 1'b0};
		if (state_q == ST_PRE) begin
			push = can_push;
			if (!ptr_q)
				push_item.char_out = CH_MINUS;
			else if (pre_q == 2'd2)
				push_item.char_out = CH_ZERO;
			else
				push_item.char_out = CH_X;
		end else if (state_q == ST_EMIT) begin
			push               = can_push;
			push_item.char_out = digit_char(top_digit, upper_q);
			push_item.last     = (left_q == LEFT_W'(1));
		end
	end

	always_comb begin
		cell_ctrl.load   = accept && op_ok;
		cell_ctrl.dabble = (state_q == ST_CONV);
		cell_ctrl.nshift = ((state_q == ST_SKIP) && (top_digit == '0) &&
		                    (left_q > LEFT_W'(1))) || ((state_q == ST_EMIT) && can_push);
	end

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic                bit_in;
		logic [DIGIT_W-1:0]  digit_in;
		if (i == 0) begin : g_first
			assign bit_in   = bin_q[BIN_W-1];
			assign digit_in = '0;
		end else begin : g_rest
			assign bit_in   = bit_w[i-1];
			assign digit_in = digit_w[i-1];
		end
		i2a_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.load_digit(ld_vec[i*DIGIT_W +: DIGIT_W]),
			.bit_in    (bit_in),
			.digit_in  (digit_in),
			.digit     (digit_w[i]),
			.bit_out   (bit_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			conv_q  <= '0;
			left_q  <= '0;
			pre_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op_ok) begin
						left_q  <= LEFT_W'(NCELL);
						conv_q  <= CONV_W'(BIN_W - 1);
						pre_q   <= (req.op == OP_PTR) ? 2'd2 : (is_neg ? 2'd1 : 2'd0);
						state_q <= is_dec ? ST_CONV : ST_SKIP;
					end
				end
				ST_CONV: begin
					conv_q <= conv_q - CONV_W'(1);
					if (conv_q == '0)
						state_q <= ST_SKIP;
				end
				ST_SKIP: begin
					if ((top_digit == '0) && (left_q > LEFT_W'(1)))
						left_q <= left_q - LEFT_W'(1);
					else
						state_q <= (pre_q != 2'd0) ? ST_PRE : ST_EMIT;
				end
				ST_PRE: begin
					if (push) begin
						pre_q <= pre_q - 2'd1;
						if (pre_q == 2'd1)
							state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (push) begin
						left_q <= left_q - LEFT_W'(1);
						if (left_q == LEFT_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op_ok) begin
			bin_q   <= is_neg ? (BIN_W'(0) - low) : low;
			ptr_q   <= (req.op == OP_PTR);
			upper_q <= (req.op == OP_HEXU);
		end else if (state_q == ST_CONV) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (push)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push)
			rsp_q <= push_item;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_emit_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (left_q != '0))
		else $error("emit with no digits left");

	a_dec_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((req.op == OP_SDEC) || (req.op == OP_UDEC))) |=> (state_q == ST_CONV))
		else $error("decimal item did not start conversion");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_item.last) |=> (state_q == ST_IDLE))
		else $error("last character without return to idle");

	a_pre_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PRE) |-> !push_item.last)
		else $error("prefix character marked last");
`endif

endmodule
